[design/q24alu_pkg.sv]
// Shared types and helpers for the Q24.8 arithmetic unit.
// No dependencies.
package q24alu_pkg;

    typedef enum logic [3:0] {
        ACT_ADD      = 4'd0,
        ACT_SUB      = 4'd1,
        ACT_MUL      = 4'd2,
        ACT_DIV      = 4'd3,
        ACT_MIN      = 4'd4,
        ACT_MAX      = 4'd5,
        ACT_INC      = 4'd6,
        ACT_DEC      = 4'd7,
        ACT_FROM_INT = 4'd8,
        ACT_TO_INT   = 4'd9
    } t_act;

    // control word that travels beside the divider data
    typedef struct packed {
        logic        vld;
        t_act        act;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        derr;
        logic        ovf;
        logic        neg;    // quotient sign
        logic [31:0] res;
    } t_ctl;

    // saturate to 32 bits; bit 32 is the overflow flag
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

[design/q24alu_front.sv]
// Front end: compare, simple actions, multiply and divider operand set-up.
// Depends on q24alu_pkg.
module q24alu_front #(
    parameter int FRAC_BITS = 8,
    parameter int NQ        = 32 + FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [3:0]          i_act,
    input  logic signed [31:0]  i_a,
    input  logic signed [31:0]  i_b,
    output q24alu_pkg::t_ctl    o_ctl,
    output logic [31:0]         o_rem,
    output logic [NQ-1:0]       o_num,
    output logic [31:0]         o_den
);
    q24alu_pkg::t_ctl   r_ctl, n_ctl;
    logic signed [63:0] r_prod;
    logic [NQ-1:0]      r_num;
    logic [31:0]        r_den;
    logic [31:0]        mag_a, mag_b;
    logic signed [63:0] a64, b64;
    logic [32:0]        sat;

    logic [63:0]        pmag, pround;
    logic signed [63:0] pval;
    logic [32:0]        psat;

    assign a64   = 64'(i_a);
    assign b64   = 64'(i_b);
    assign mag_a = i_a[31] ? 32'(-a64) : i_a;
    assign mag_b = i_b[31] ? 32'(-b64) : i_b;

    always_comb begin
        n_ctl      = '0;
        n_ctl.vld  = i_vld;
        n_ctl.act  = q24alu_pkg::t_act'(i_act);
        n_ctl.lt   = i_a < i_b;
        n_ctl.eq   = i_a == i_b;
        n_ctl.gt   = i_a > i_b;
        n_ctl.neg  = i_a[31] ^ i_b[31];
        sat        = '0;
        unique case (n_ctl.act)
            q24alu_pkg::ACT_ADD:      sat = q24alu_pkg::sat32(a64 + b64);
            q24alu_pkg::ACT_SUB:      sat = q24alu_pkg::sat32(a64 - b64);
            q24alu_pkg::ACT_INC:      sat = q24alu_pkg::sat32(a64 + 64'sd1);
            q24alu_pkg::ACT_DEC:      sat = q24alu_pkg::sat32(a64 - 64'sd1);
            q24alu_pkg::ACT_FROM_INT: sat = q24alu_pkg::sat32(a64 <<< FRAC_BITS);
            q24alu_pkg::ACT_TO_INT:   sat = {1'b0, 32'(i_a >>> FRAC_BITS)};
            q24alu_pkg::ACT_MIN:      sat = {1'b0, (i_a > i_b) ? i_b : i_a};
            q24alu_pkg::ACT_MAX:      sat = {1'b0, (i_a > i_b) ? i_a : i_b};
            q24alu_pkg::ACT_DIV:      sat = '0;
            q24alu_pkg::ACT_MUL:      sat = '0;
            default:                  sat = '0;
        endcase
        n_ctl.ovf  = sat[32];
        n_ctl.res  = sat[31:0];
        n_ctl.derr = (n_ctl.act == q24alu_pkg::ACT_DIV) && (i_b == 32'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r_ctl  <= n_ctl;
            r_prod <= i_a * i_b;
            r_num  <= {mag_a, {FRAC_BITS{1'b0}}};
            r_den  <= mag_b;
        end
    end

    // second stage: round the product half away from zero
    assign pmag   = r_prod[63] ? 64'(-r_prod) : 64'(r_prod);
    assign pround = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign pval   = r_prod[63] ? -$signed(pround) : $signed(pround);
    assign psat   = q24alu_pkg::sat32(pval);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.vld <= 1'b0;
        end else if (i_en) begin
            o_ctl <= r_ctl;
            if (r_ctl.act == q24alu_pkg::ACT_MUL) begin
                o_ctl.res <= psat[31:0];
                o_ctl.ovf <= psat[32];
            end
            o_rem <= '0;
            o_num <= r_num;
            o_den <= r_den;
        end
    end
endmodule

[design/q24alu_cell.sv]
// One restoring-division cell: produces one quotient bit per stage.
// Depends on q24alu_pkg.
module q24alu_cell #(
    parameter int NQ = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  q24alu_pkg::t_ctl i_ctl,
    input  logic [31:0]      i_rem,
    input  logic [NQ-1:0]    i_num,
    input  logic [31:0]      i_den,
    output q24alu_pkg::t_ctl o_ctl,
    output logic [31:0]      o_rem,
    output logic [NQ-1:0]    o_num,
    output logic [31:0]      o_den
);
    logic [32:0] trial, diff;
    logic        qbit;

    assign trial = {i_rem, i_num[NQ-1]};
    assign diff  = trial - {1'b0, i_den};
    assign qbit  = trial >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.vld <= 1'b0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
            o_rem <= qbit ? diff[31:0] : trial[31:0];
            o_num <= {i_num[NQ-2:0], qbit};   // quotient bits fill in from the bottom
            o_den <= i_den;
        end
    end
endmodule

[design/q24alu_back.sv]
// Back end: quotient rounding and saturation, result select, output register.
// Depends on q24alu_pkg.
module q24alu_back #(
    parameter int NQ = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  q24alu_pkg::t_ctl i_ctl,
    input  logic [31:0]      i_rem,
    input  logic [NQ-1:0]    i_quo,
    input  logic [31:0]      i_den,
    output logic             o_vld,
    output logic [31:0]      o_res,
    output logic [4:0]       o_flags
);
    logic [NQ:0]        q1;
    logic signed [63:0] qval;
    logic [32:0]        qsat;
    logic [31:0]        res;
    logic               ovf;

    assign q1   = {1'b0, i_quo} + (NQ+1)'({i_rem, 1'b0} >= {1'b0, i_den});
    assign qval = i_ctl.neg ? -$signed(64'(q1)) : $signed(64'(q1));
    assign qsat = q24alu_pkg::sat32(qval);

    always_comb begin
        res = i_ctl.res;
        ovf = i_ctl.ovf;
        if (i_ctl.act == q24alu_pkg::ACT_DIV) begin
            res = i_ctl.derr ? 32'd0 : qsat[31:0];
            ovf = i_ctl.derr ? 1'b0  : qsat[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld   <= i_ctl.vld;
            o_res   <= res;
            o_flags <= {ovf, i_ctl.derr, i_ctl.gt, i_ctl.eq, i_ctl.lt};
        end
    end
endmodule

[design/q24_8_fixed_point_alu_top.sv]
// Q24.8 fixed-point arithmetic unit, pipelined.
// Pipeline: two front stages, a chain of 32 + FRAC_BITS division cells, one output register.
// Throughput: one request per cycle; the whole pipe holds only while a result is refused.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
// Depends on q24alu_pkg, q24alu_front, q24alu_cell, q24alu_back.
module q24_8_fixed_point_alu_top #(
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  logic [3:0]  s_axis_tuser,   // [3:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] result
    output logic [4:0]  m_axis_tuser    // a_less, a_equal, a_greater, divide_error, overflow
);
    localparam int NQ = 32 + FRAC_BITS;   // quotient bits, one per cell

    logic en;

    // cell chain links: index 0 is the front end's output
    q24alu_pkg::t_ctl ctl [0:NQ];
    logic [31:0]      rem [0:NQ];
    logic [NQ-1:0]    num [0:NQ];
    logic [31:0]      den [0:NQ];

    // the pipe advances unless the output register holds a refused result
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    q24alu_front #(.FRAC_BITS(FRAC_BITS), .NQ(NQ)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_axis_tvalid),
        .i_act   (s_axis_tuser),
        .i_a     ($signed(s_axis_tdata[31:0])),
        .i_b     ($signed(s_axis_tdata[63:32])),
        .o_ctl   (ctl[0]),
        .o_rem   (rem[0]),
        .o_num   (num[0]),
        .o_den   (den[0])
    );

    // each cell settles one quotient bit, MSB first
    for (genvar g = 0; g < NQ; g++) begin : g_cell
        q24alu_cell #(.NQ(NQ)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl[g]),
            .i_rem   (rem[g]),
            .i_num   (num[g]),
            .i_den   (den[g]),
            .o_ctl   (ctl[g+1]),
            .o_rem   (rem[g+1]),
            .o_num   (num[g+1]),
            .o_den   (den[g+1])
        );
    end

    q24alu_back #(.NQ(NQ)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (ctl[NQ]),
        .i_rem   (rem[NQ]),
        .i_quo   (num[NQ]),
        .i_den   (den[NQ]),
        .o_vld   (m_axis_tvalid),
        .o_res   (m_axis_tdata),
        .o_flags (m_axis_tuser)
    );
endmodule

[design/q24alu_chk.sv]
// Port-level checks for the Q24.8 arithmetic unit, bound to the top level.
// Depends on q24_8_fixed_point_alu_top.
module q24alu_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [4:0]  m_axis_tuser
);
    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot(m_axis_tuser[2:0]))
        else $error("compare flags not exclusive");

    a_derr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[3]) |-> (m_axis_tdata == 32'd0 && !m_axis_tuser[4]))
        else $error("divide error with nonzero result or overflow");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready disagrees with output stall");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result dropped or changed");
endmodule

bind q24_8_fixed_point_alu_top q24alu_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
